/* rtl/core/glost_pkg.sv */
// Shared types and constants for the grid line-of-sight tracer.
`default_nettype none

package glost_pkg;

    // Default coordinate width of one grid axis.
    localparam int COORD_BITS_DEF = 6;

    // Depth of the descriptor queue between front and back.
    localparam int Q_DEPTH = 2;

    // Direction flags of one ray, computed by the front and used by the back.
    typedef struct packed {
        logic long_is_i;  // long axis is the row axis
        logic l_neg;      // long axis steps downward
        logic s_move;     // short axis moves at all
        logic s_neg;      // short axis steps downward
    } t_ray_flags;

    localparam int FLAGS_W = $bits(t_ray_flags);

endpackage

`default_nettype wire

/* rtl/core/glost_front.sv */
// Front end: takes endpoint transactions and classifies them into ray descriptors.
`default_nettype none

module glost_front
    import glost_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int DESC_W = FLAGS_W + 4 * COORD_BITS + 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [COORD_BITS-1:0] i_src_i,
    input  wire logic [COORD_BITS-1:0] i_src_j,
    input  wire logic [COORD_BITS-1:0] i_tgt_i,
    input  wire logic [COORD_BITS-1:0] i_tgt_j,
    output logic                       o_q_valid,
    input  wire logic                  i_q_stall,
    output logic [DESC_W-1:0]          o_q_desc
);

    logic signed [COORD_BITS:0] di;
    logic signed [COORD_BITS:0] dj;
    logic signed [COORD_BITS:0] dl;
    logic signed [COORD_BITS:0] ds;
    logic signed [COORD_BITS:0] neg_di;
    logic signed [COORD_BITS:0] neg_dj;
    logic signed [COORD_BITS:0] neg_dl;
    logic [COORD_BITS-1:0]      abs_di;
    logic [COORD_BITS-1:0]      abs_dj;
    logic [COORD_BITS-1:0]      len;
    logic [COORD_BITS-1:0]      l0;
    logic [COORD_BITS-1:0]      s0;
    t_ray_flags                 flags;
    logic                       accept;

    logic                       r_valid;
    logic                       n_valid;
    logic [DESC_W-1:0]          r_desc;
    logic [DESC_W-1:0]          n_desc;

    always_comb begin
        di     = $signed({1'b0, i_tgt_i}) - $signed({1'b0, i_src_i});
        dj     = $signed({1'b0, i_tgt_j}) - $signed({1'b0, i_src_j});
        neg_di = -di;
        neg_dj = -dj;
        abs_di = di[COORD_BITS] ? neg_di[COORD_BITS-1:0] : di[COORD_BITS-1:0];
        abs_dj = dj[COORD_BITS] ? neg_dj[COORD_BITS-1:0] : dj[COORD_BITS-1:0];

        // ties go to the column axis
        flags.long_is_i = abs_di > abs_dj;
        dl     = flags.long_is_i ? di : dj;
        ds     = flags.long_is_i ? dj : di;
        l0     = flags.long_is_i ? i_src_i : i_src_j;
        s0     = flags.long_is_i ? i_src_j : i_src_i;
        neg_dl = -dl;
        len    = dl[COORD_BITS] ? neg_dl[COORD_BITS-1:0] : dl[COORD_BITS-1:0];

        flags.l_neg  = dl[COORD_BITS];
        flags.s_move = ds != '0;
        flags.s_neg  = ds[COORD_BITS];

        n_desc = {flags, l0, s0, ds, len};
    end

    assign o_stall = r_valid && i_q_stall;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (!i_q_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_desc <= n_desc;
        end
    end

    assign o_q_valid = r_valid;
    assign o_q_desc  = r_desc;

endmodule

`default_nettype wire

/* rtl/core/glost_queue.sv */
// Short descriptor queue between the front end and the ray walker.
`default_nettype none

module glost_queue
    import glost_pkg::*;
#(
    parameter int DATA_W = 8,
    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1,
    localparam int CNT_W = $clog2(Q_DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_valid,
    input  wire logic              i_pop,
    output logic [DATA_W-1:0]      o_data
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(Q_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(Q_DEPTH - 1);

    logic [DATA_W-1:0] r_mem [Q_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic              push;
    logic              pop;

    assign o_stall = r_cnt == FULL_CNT;
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/glost_walker.sv */
// Back end: walks one ray descriptor, one cell per transaction.
`default_nettype none

module glost_walker
    import glost_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int DESC_W = FLAGS_W + 4 * COORD_BITS + 1,
    localparam int ERR_W  = COORD_BITS + 3
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_valid,
    output logic                       o_q_pop,
    input  wire logic [DESC_W-1:0]     i_q_desc,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [COORD_BITS-1:0]      o_cell_i,
    output logic [COORD_BITS-1:0]      o_cell_j,
    output logic                       o_last_cell
);

    t_ray_flags                 d_flags;
    logic [COORD_BITS-1:0]      d_l0;
    logic [COORD_BITS-1:0]      d_s0;
    logic signed [COORD_BITS:0] d_ds;
    logic [COORD_BITS-1:0]      d_len;

    // walk state
    t_ray_flags                 r_flags;
    logic [COORD_BITS-1:0]      r_l;
    logic [COORD_BITS-1:0]      r_s;
    logic signed [ERR_W-1:0]    r_err;
    logic signed [COORD_BITS:0] r_ds;
    logic [COORD_BITS-1:0]      r_len;
    logic [COORD_BITS-1:0]      r_left;   // cells still to emit after current
    logic                       r_out_valid;
    logic [COORD_BITS-1:0]      r_cell_i;
    logic [COORD_BITS-1:0]      r_cell_j;
    logic                       r_last;

    logic                       out_free;
    logic                       busy;
    logic                       do_load;
    logic                       do_step;
    logic signed [ERR_W-1:0]    err_sum;
    logic signed [ERR_W-1:0]    err_neg;
    logic [ERR_W-1:0]           err_mag2;
    logic [ERR_W-1:0]           len_ext;
    logic                       s_step;
    logic [COORD_BITS-1:0]      n_l;
    logic [COORD_BITS-1:0]      n_s;
    logic signed [ERR_W-1:0]    n_err;

    assign {d_flags, d_l0, d_s0, d_ds, d_len} = i_q_desc;

    assign busy     = r_left != '0;
    assign out_free = !r_out_valid || !i_stall;
    assign do_step  = busy && out_free;
    assign do_load  = !busy && out_free && i_q_valid;
    assign o_q_pop  = do_load;

    always_comb begin
        len_ext  = ERR_W'(r_len);
        err_sum  = r_err + ERR_W'(r_ds);
        err_neg  = -err_sum;
        // |err| stays below 1.5 * len, so twice it fits in ERR_W bits
        err_mag2 = (err_sum[ERR_W-1] ? err_neg : err_sum) <<< 1;
        s_step   = r_flags.s_move && (err_mag2 >= len_ext);

        n_l = r_flags.l_neg ? r_l - 1'b1 : r_l + 1'b1;
        n_s = r_s;
        n_err = err_sum;
        if (s_step) begin
            n_s   = r_flags.s_neg ? r_s - 1'b1 : r_s + 1'b1;
            n_err = r_flags.s_neg ? err_sum + $signed(len_ext)
                                  : err_sum - $signed(len_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (do_load) begin
                r_left      <= d_len;
                r_out_valid <= 1'b1;
            end else if (do_step) begin
                r_left      <= r_left - 1'b1;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_flags  <= d_flags;
            r_l      <= d_l0;
            r_s      <= d_s0;
            r_err    <= '0;
            r_ds     <= d_ds;
            r_len    <= d_len;
            r_cell_i <= d_flags.long_is_i ? d_l0 : d_s0;
            r_cell_j <= d_flags.long_is_i ? d_s0 : d_l0;
            r_last   <= d_len == '0;
        end else if (do_step) begin
            r_l      <= n_l;
            r_s      <= n_s;
            r_err    <= n_err;
            r_cell_i <= r_flags.long_is_i ? n_l : n_s;
            r_cell_j <= r_flags.long_is_i ? n_s : n_l;
            r_last   <= r_left == COORD_BITS'(1);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_cell_i    = r_cell_i;
    assign o_cell_j    = r_cell_j;
    assign o_last_cell = r_last;

endmodule

`default_nettype wire

/* rtl/core/grid_line_of_sight_tracer_unit.sv */
// Top level of the grid line-of-sight tracer: front end, descriptor queue, ray walker.
//
// Traces the Bresenham ray from a source cell to a target cell on a square grid
// of 2^COORD_BITS cells per side, in all octants. Each input transaction carries
// the two endpoints; the unit answers with max(|di|,|dj|)+1 output transactions,
// one per ray cell, source first and target last, with o_last_cell set only on
// the target. Equal endpoints give a single cell with o_last_cell set. The long
// axis is the row axis only when |di| > |dj|; ties walk along columns. Rate: the
// walker emits one cell per clock while unstalled (64 cells for the longest ray
// at the default width) and loads the next ray once the previous ray's last cell
// is out and the output is free. The front end classifies incoming endpoints into
// a descriptor (one register stage) and a two-entry queue buffers descriptors, so
// new endpoints are taken while a ray is still being walked. From an empty unit,
// an input passes the front-end register, a queue entry and the walker output
// register before its first cell appears. No configuration, no state across
// rays, nothing to clear after reset beyond the handshake control.
`default_nettype none

module grid_line_of_sight_tracer_unit
    import glost_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // endpoint transactions
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [COORD_BITS-1:0] i_src_i,
    input  wire logic [COORD_BITS-1:0] i_src_j,
    input  wire logic [COORD_BITS-1:0] i_tgt_i,
    input  wire logic [COORD_BITS-1:0] i_tgt_j,
    // ray cell transactions
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [COORD_BITS-1:0]      o_cell_i,
    output logic [COORD_BITS-1:0]      o_cell_j,
    output logic                       o_last_cell
);

    // descriptor: flags, long start, short start, signed short delta, length
    localparam int DESC_W = FLAGS_W + 4 * COORD_BITS + 1;

    logic              fe_valid;
    logic              fe_stall;
    logic [DESC_W-1:0] fe_desc;
    logic              q_valid;
    logic              q_pop;
    logic [DESC_W-1:0] q_desc;

    glost_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_src_i   (i_src_i),
        .i_src_j   (i_src_j),
        .i_tgt_i   (i_tgt_i),
        .i_tgt_j   (i_tgt_j),
        .o_q_valid (fe_valid),
        .i_q_stall (fe_stall),
        .o_q_desc  (fe_desc)
    );

    // decouples classification from the walk
    glost_queue #(
        .DATA_W (DESC_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fe_valid),
        .o_stall (fe_stall),
        .i_data  (fe_desc),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_desc)
    );

    // error accumulator walk, output register doubles as the skid stage
    glost_walker #(
        .COORD_BITS (COORD_BITS)
    ) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_desc    (q_desc),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_cell_i    (o_cell_i),
        .o_cell_j    (o_cell_j),
        .o_last_cell (o_last_cell)
    );

endmodule

`default_nettype wire

/* tb/sv/grid_line_of_sight_tracer_unit_tb.sv */
// Testbench for the grid line-of-sight tracer: random endpoints, predicted ray cells, scoreboard.
`timescale 1ns / 1ps

module grid_line_of_sight_tracer_unit_tb
    import glost_pkg::*;
;

    localparam int CB = COORD_BITS_DEF;
    localparam int COORD_MAX = (1 << CB) - 1;
    localparam int N_RANDOM = 360;
    // Slowest legal run: ~380 rays x 64 cells x heavy output stall, plus sender gaps.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 16;

    typedef logic [CB-1:0] t_coord;

    // One ray cell as it should leave the block.
    typedef struct packed {
        t_coord ci;
        t_coord cj;
        logic   last;
    } t_ray_cell;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    // ------------------------------------------------------------------------
    // Scoreboard: expands each accepted endpoint pair into its Bresenham ray
    // and checks the output cells against that list in order.
    // ------------------------------------------------------------------------
    class ray_scoreboard;
        t_ray_cell expected_cells[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        function int abs_int(int v);
            return (v < 0) ? -v : v;
        endfunction

        function int sign_int(int v);
            return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
        endfunction

        function int pending();
            return expected_cells.size();
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // Walks the ray from source to target; the long axis is rows only
        // when |di| strictly exceeds |dj|, so ties walk along columns.
        function void note_endpoints(t_coord si, t_coord sj, t_coord ti, t_coord tj);
            int        di, dj, dl, ds, pos_l, pos_s, step_l, step_s, span, err_acc;
            bit        rows_long;
            t_ray_cell c;
            di = int'(ti) - int'(si);
            dj = int'(tj) - int'(sj);
            rows_long = abs_int(di) > abs_int(dj);
            dl = rows_long ? di : dj;
            ds = rows_long ? dj : di;
            pos_l = rows_long ? int'(si) : int'(sj);
            pos_s = rows_long ? int'(sj) : int'(si);
            step_l = sign_int(dl);
            step_s = sign_int(ds);
            span = abs_int(dl);
            err_acc = 0;
            c.ci = si;
            c.cj = sj;
            c.last = (span == 0);
            expected_cells.push_back(c);
            for (int k = 1; k <= span; k++) begin
                pos_l += step_l;
                err_acc += ds;
                // short axis steps once twice the error magnitude reaches the span
                if (2 * abs_int(err_acc) >= span) begin
                    err_acc -= span * step_s;
                    pos_s += step_s;
                end
                c.ci = rows_long ? pos_l[CB-1:0] : pos_s[CB-1:0];
                c.cj = rows_long ? pos_s[CB-1:0] : pos_l[CB-1:0];
                c.last = (k == span);
                expected_cells.push_back(c);
            end
        endfunction

        task check_cell(t_coord ci, t_coord cj, logic last);
            t_ray_cell exp_c;
            if (expected_cells.size() == 0) begin
                report($sformatf("unexpected cell (%0d,%0d) last=%0b", ci, cj, last));
            end else begin
                exp_c = expected_cells.pop_front();
                if (ci !== exp_c.ci)
                    report($sformatf("cell_i got %0d exp %0d", ci, exp_c.ci));
                if (cj !== exp_c.cj)
                    report($sformatf("cell_j got %0d exp %0d", cj, exp_c.cj));
                if (last !== exp_c.last)
                    report($sformatf("last_cell got %0b exp %0b at (%0d,%0d)",
                                     last, exp_c.last, exp_c.ci, exp_c.cj));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value.
    // ------------------------------------------------------------------------
    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   o_stall;
    t_coord i_src_i = '0;
    t_coord i_src_j = '0;
    t_coord i_tgt_i = '0;
    t_coord i_tgt_j = '0;
    logic   o_valid;
    logic   i_stall = 1'b0;
    t_coord o_cell_i;
    t_coord o_cell_j;
    logic   o_last_cell;

    ray_scoreboard sb = new();
    int            cycle_count = 0;
    int            burst_left = 0;
    t_stall_mode   stall_mode = STALL_NONE;
    int            stall_hold = 0;

    grid_line_of_sight_tracer_unit #(
        .COORD_BITS(CB)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_src_i    (i_src_i),
        .i_src_j    (i_src_j),
        .i_tgt_i    (i_tgt_i),
        .i_tgt_j    (i_tgt_j),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_cell_i   (o_cell_i),
        .o_cell_j   (o_cell_j),
        .o_last_cell(o_last_cell)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: the run must end well inside the limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Both channels are sampled at the edge, before any NBA update lands.
    // An input transaction is predicted here, its cells checked in the same block,
    // so ordering never depends on which process wakes first.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_endpoints(i_src_i, i_src_j, i_tgt_i, i_tgt_j);
            if (o_valid && !i_stall)
                sb.check_cell(o_cell_i, o_cell_j, o_last_cell);
        end
    end

    // Output back-pressure: the mode is redrawn at random intervals, so stall-free
    // stretches alternate with light, heavy and periodic stalling.
    always @(posedge i_clk) begin
        if (stall_hold == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_hold <= $urandom_range(20, 300);
        end else begin
            stall_hold <= stall_hold - 1;
        end
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            default:     i_stall <= ((cycle_count % 7) < 3);
        endcase
    end

    // Presents one endpoint pair and holds it until the handshake completes.
    // Bursts end with an idle gap; within a burst valid stays high, so it is never
    // lowered and raised in the same step.
    task send_endpoints(input t_coord si, input t_coord sj, input t_coord ti, input t_coord tj);
        int gap;
        i_valid <= 1'b1;
        i_src_i <= si;
        i_src_j <= sj;
        i_tgt_i <= ti;
        i_tgt_j <= tj;
        do @(posedge i_clk); while (o_stall);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(1, 10);
            gap = $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    function t_coord clamp_coord(int v);
        if (v < 0)
            return '0;
        if (v > COORD_MAX)
            return t_coord'(COORD_MAX);
        return v[CB-1:0];
    endfunction

    initial begin
        t_coord si, sj, ti, tj;
        int     kind;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: degenerate rays, grid corners, every octant, ties, and
        // the error hitting the threshold exactly in both signs.
        send_endpoints(0, 0, 0, 0);                 // source equals target
        send_endpoints(63, 63, 63, 63);
        send_endpoints(21, 42, 21, 42);
        send_endpoints(0, 0, 63, 63);               // tie: walks along columns
        send_endpoints(63, 63, 0, 0);
        send_endpoints(0, 63, 63, 0);
        send_endpoints(0, 0, 63, 0);                // pure row move
        send_endpoints(63, 0, 0, 0);
        send_endpoints(0, 63, 0, 0);                // pure column move
        send_endpoints(0, 0, 0, 63);
        send_endpoints(0, 0, 63, 62);               // long rows, shallow
        send_endpoints(0, 0, 62, 63);               // long columns
        send_endpoints(63, 63, 0, 1);
        send_endpoints(0, 0, 4, 2);                 // error meets the span exactly
        send_endpoints(0, 4, 4, 2);                 // same, negative error
        send_endpoints(10, 10, 12, 14);
        send_endpoints(10, 10, 8, 6);
        send_endpoints(32, 32, 35, 28);             // remaining octants
        send_endpoints(32, 32, 28, 35);
        send_endpoints(32, 32, 29, 27);
        send_endpoints(32, 32, 27, 36);
        send_endpoints(5, 5, 6, 6);                 // one-step diagonal
        send_endpoints(42, 21, 21, 42);

        // Random: mostly full-range endpoints, plus short rays and aligned or
        // degenerate ones.
        for (int n = 0; n < N_RANDOM; n++) begin
            si = t_coord'($urandom);
            sj = t_coord'($urandom);
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                ti = t_coord'($urandom);
                tj = t_coord'($urandom);
            end else if (kind <= 8) begin
                ti = clamp_coord(int'(si) + $urandom_range(0, 10) - 5);
                tj = clamp_coord(int'(sj) + $urandom_range(0, 10) - 5);
            end else begin
                ti = ($urandom_range(0, 2) == 0) ? si : t_coord'($urandom);
                tj = ($urandom_range(0, 1) == 0) ? sj : t_coord'($urandom);
            end
            send_endpoints(si, sj, ti, tj);
        end

        i_valid <= 1'b0;
        // Drain: every predicted cell must come out, then nothing more may follow.
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/glost_pkg.sv
rtl/core/glost_front.sv
rtl/core/glost_queue.sv
rtl/core/glost_walker.sv
rtl/core/grid_line_of_sight_tracer_unit.sv
tb/sv/grid_line_of_sight_tracer_unit_tb.sv
